FILE: sv/lsep_pkg.sv
`timescale 1ns / 1ps
// Laser scan end point projection: shared types, constants and tables.
// No dependencies.
package lsep_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int RANGE_BITS    = 16;

	localparam int ANG_W      = 16;
	localparam int OFF_W      = 24;
	localparam int LIM_W      = 16;
	localparam int IN_RANGE_W = 16;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// CORDIC vector width: range * gain (Q16) plus growth and sign
	localparam int XW      = RANGE_BITS + 19;
	// angle width in Q24 with room for the wrap adjust
	localparam int ZW      = 29;
	localparam int SHIFT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
	// rounded coordinate and offset sum widths
	localparam int RW      = XW - 16;
	localparam int SW      = ((RW > OFF_W) ? RW : OFF_W) + 1;

	localparam logic signed [ZW-1:0] PI_Q24        = ZW'(52707179);
	localparam logic signed [ZW-1:0] NEG_PI_Q24    = -ZW'(52707179);
	localparam logic signed [ZW-1:0] TWO_PI_Q24    = ZW'(105414357);
	localparam logic signed [ZW-1:0] NEG_TWO_PI    = -ZW'(105414357);
	localparam logic signed [ZW-1:0] FOUR_PI_Q24   = ZW'(210828714);
	localparam logic signed [ZW-1:0] NEG_FOUR_PI   = -ZW'(210828714);
	// pi + 2pi as the wrap steps see it
	localparam logic signed [ZW-1:0] THREE_PI_Q24  = ZW'(158121536);
	localparam logic signed [ZW-1:0] NEG_THREE_PI  = -ZW'(158121536);
	localparam logic signed [ZW-1:0] HALF_PI_Q24   = ZW'(26353589);
	localparam logic signed [ZW-1:0] NEG_HALF_PI   = -ZW'(26353589);

	localparam logic [15:0] GAIN_Q16 = 16'd39797;

	localparam logic signed [SW-1:0] OUT_MAX = SW'(8388607);
	localparam logic signed [SW-1:0] OUT_MIN = -SW'(8388608);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ANGLE = 3'd0,
		REG_END_ANGLE   = 3'd1,
		REG_ANGLE_STEP  = 3'd2,
		REG_MIN_RANGE   = 3'd3,
		REG_MAX_RANGE   = 3'd4,
		REG_HEADING     = 3'd5,
		REG_OFFSET_X    = 3'd6,
		REG_OFFSET_Y    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] start_angle;
		logic signed [ANG_W-1:0] end_angle;
		logic signed [ANG_W-1:0] angle_step;
		logic [LIM_W-1:0]        min_range;
		logic [LIM_W-1:0]        max_range;
		logic signed [ANG_W-1:0] heading;
		logic signed [OFF_W-1:0] offset_x;
		logic signed [OFF_W-1:0] offset_y;
	} cfg_regs_t;

	typedef struct packed {
		logic              valid;
		logic              neg;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	localparam logic [ZW-1:0] ATAN_Q24 [24] = '{
		ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331),
		ZW'(1047214), ZW'(524117), ZW'(262123), ZW'(131069),
		ZW'(65536), ZW'(32768), ZW'(16384), ZW'(8192),
		ZW'(4096), ZW'(2048), ZW'(1024), ZW'(512),
		ZW'(256), ZW'(128), ZW'(64), ZW'(32),
		ZW'(16), ZW'(8), ZW'(4), ZW'(2)
	};

	function automatic logic signed [ZW-1:0] atan_at(input logic [SHIFT_W-1:0] i);
		atan_at = signed'(ATAN_Q24[i]);
	endfunction

endpackage

FILE: sv/lsep_if.sv
`timescale 1ns / 1ps
// Stream and configuration interfaces of the end point projection block.
// Depends on lsep_pkg.
interface lsep_in_if import lsep_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [IN_RANGE_W-1:0] range_mm;
	logic                  first_beam;

	modport source (output valid, range_mm, first_beam, input ready);
	modport sink (input valid, range_mm, first_beam, output ready);
endinterface

interface lsep_out_if import lsep_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] end_x;
	logic signed [OUT_W-1:0] end_y;
	logic                    clipped;

	modport source (output valid, end_x, end_y, clipped, input ready);
	modport sink (input valid, end_x, end_y, clipped, output ready);
endinterface

interface lsep_cfg_if import lsep_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/laser_scan_endpoint_projection_top.sv
`timescale 1ns / 1ps
// Laser range sample to map-frame end point: CORDIC_STAGES + 5 register stages;
// one sample per cycle whenever the pipeline advances.
// The whole pipeline stalls only while the output register holds a result
// that is not taken. Reset clears the pipeline valids, the beam angle and
// the registers (max_range resets to 65535). Depends on lsep_pkg, lsep_if.
module laser_scan_endpoint_projection_top import lsep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lsep_in_if.sink    scan,
	lsep_out_if.source point,
	lsep_cfg_if.sink   cfg
);

	cfg_regs_t regs_q;
	cordic_t   stage [CORDIC_STAGES+1];
	logic      adv;
	logic      take;
	logic      out_valid;

	assign adv        = !out_valid || point.ready;
	assign take       = scan.valid && adv;
	assign scan.ready = adv;
	assign cfg.ready  = 1'b1;
	assign point.valid = out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{max_range: {LIM_W{1'b1}}, default: '0};
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_START_ANGLE: regs_q.start_angle <= cfg.data[ANG_W-1:0];
				REG_END_ANGLE:   regs_q.end_angle   <= cfg.data[ANG_W-1:0];
				REG_ANGLE_STEP:  regs_q.angle_step  <= cfg.data[ANG_W-1:0];
				REG_MIN_RANGE:   regs_q.min_range   <= cfg.data[LIM_W-1:0];
				REG_MAX_RANGE:   regs_q.max_range   <= cfg.data[LIM_W-1:0];
				REG_HEADING:     regs_q.heading     <= cfg.data[ANG_W-1:0];
				REG_OFFSET_X:    regs_q.offset_x    <= cfg.data[OFF_W-1:0];
				REG_OFFSET_Y:    regs_q.offset_y    <= cfg.data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	lsep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.take       (take),
		.range_mm   (scan.range_mm),
		.first_beam (scan.first_beam),
		.regs       (regs_q),
		.cell_in    (stage[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		lsep_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.shift  (SHIFT_W'(g)),
			.d      (stage[g]),
			.q      (stage[g+1])
		);
	end

	lsep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cell_out  (stage[CORDIC_STAGES]),
		.regs      (regs_q),
		.out_valid (out_valid),
		.end_x     (point.end_x),
		.end_y     (point.end_y),
		.clipped   (point.clipped)
	);

endmodule

FILE: sv/lsep_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on lsep_pkg.
module lsep_cordic_cell import lsep_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [SHIFT_W-1:0] shift,
	input  cordic_t            d,
	output cordic_t            q
);

	cordic_t nxt;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] at;

	always_comb begin
		xs  = d.x >>> shift;
		ys  = d.y >>> shift;
		at  = atan_at(shift);
		nxt = d;
		if (!d.z[ZW-1]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else if (adv) begin
			q <= nxt;
		end
	end

endmodule

FILE: sv/lsep_front.sv
`timescale 1ns / 1ps
// Front end: range window, beam angle accumulator, angle wrap and fold.
// Depends on lsep_pkg.
module lsep_front import lsep_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  take,
	input  logic [IN_RANGE_W-1:0] range_mm,
	input  logic                  first_beam,
	input  cfg_regs_t             regs,
	output cordic_t               cell_in
);

	logic signed [ANG_W-1:0] next_angle_q;
	logic signed [ANG_W-1:0] beam;
	logic signed [ANG_W:0]   step_sum;
	logic signed [ANG_W:0]   end_ext;
	logic signed [ANG_W:0]   head_sum;
	logic [RANGE_BITS-1:0]   rng;
	logic                    in_win;
	logic                    wrap;

	logic                 valid_s1, valid_s2;
	logic signed [ZW-1:0] z_s1, z_s2;
	logic signed [XW-1:0] x_s1, x_s2;
	logic signed [ZW-1:0] wrap_add;
	logic signed [ZW-1:0] fold_add;
	logic                 fold;

	always_comb begin
		rng      = RANGE_BITS'(range_mm);
		beam     = first_beam ? regs.start_angle : next_angle_q;
		in_win   = (32'(rng) >= 32'(regs.min_range)) && (32'(rng) < 32'(regs.max_range));
		step_sum = (ANG_W+1)'(beam) + (ANG_W+1)'(regs.angle_step);
		end_ext  = (ANG_W+1)'(regs.end_angle);
		head_sum = (ANG_W+1)'(beam) + (ANG_W+1)'(regs.heading);
		wrap     = (end_ext < 0) ? (step_sum <= end_ext) : (step_sum >= end_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_angle_q <= '0;
		end else if (take) begin
			next_angle_q <= wrap ? regs.start_angle : step_sum[ANG_W-1:0];
		end
	end

	// s1: scaled angle and initial vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take && in_win;
			z_s1     <= ZW'(head_sum) <<< 11;
			x_s1     <= signed'(XW'(rng) * XW'(GAIN_Q16));
		end
	end

	// s2: wrap into [-pi, pi]
	always_comb begin
		if (z_s1 > THREE_PI_Q24)
			wrap_add = NEG_FOUR_PI;
		else if (z_s1 > PI_Q24)
			wrap_add = NEG_TWO_PI;
		else if (z_s1 < NEG_THREE_PI)
			wrap_add = FOUR_PI_Q24;
		else if (z_s1 < NEG_PI_Q24)
			wrap_add = TWO_PI_Q24;
		else
			wrap_add = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			z_s2     <= z_s1 + wrap_add;
			x_s2     <= x_s1;
		end
	end

	// s3: fold into [-pi/2, pi/2], negate at the end
	always_comb begin
		fold     = 1'b0;
		fold_add = '0;
		if (z_s2 > HALF_PI_Q24) begin
			fold     = 1'b1;
			fold_add = NEG_PI_Q24;
		end else if (z_s2 < NEG_HALF_PI) begin
			fold     = 1'b1;
			fold_add = PI_Q24;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_in.valid <= 1'b0;
		end else if (adv) begin
			cell_in.valid <= valid_s2;
			cell_in.neg   <= fold;
			cell_in.x     <= x_s2;
			cell_in.y     <= '0;
			cell_in.z     <= z_s2 + fold_add;
		end
	end

endmodule

FILE: sv/lsep_back.sv
`timescale 1ns / 1ps
// Back end: sign restore, rounding to mm, offset, saturation, output register.
// Depends on lsep_pkg.
module lsep_back import lsep_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  cordic_t                 cell_out,
	input  cfg_regs_t               regs,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] end_x,
	output logic signed [OUT_W-1:0] end_y,
	output logic                    clipped
);

	localparam logic signed [XW-1:0] RND     = XW'(32768);
	localparam logic signed [XW-1:0] RND_NEG = XW'(32769);

	logic                 valid_s1;
	logic signed [RW-1:0] rx_s1, ry_s1;
	logic signed [XW-1:0] vx, vy;
	logic signed [SW-1:0] sx, sy;
	logic                 cx_hi, cx_lo, cy_hi, cy_lo;

	// -v + 2^15 == ~v + 2^15 + 1
	always_comb begin
		vx = cell_out.neg ? (~cell_out.x + RND_NEG) : (cell_out.x + RND);
		vy = cell_out.neg ? (~cell_out.y + RND_NEG) : (cell_out.y + RND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cell_out.valid;
			rx_s1    <= vx[XW-1:16];
			ry_s1    <= vy[XW-1:16];
		end
	end

	always_comb begin
		sx    = SW'(rx_s1) + SW'(regs.offset_x);
		sy    = SW'(ry_s1) + SW'(regs.offset_y);
		cx_hi = sx > OUT_MAX;
		cx_lo = sx < OUT_MIN;
		cy_hi = sy > OUT_MAX;
		cy_lo = sy < OUT_MIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
			end_x     <= cx_hi ? OUT_W'(OUT_MAX) : (cx_lo ? OUT_W'(OUT_MIN) : OUT_W'(sx));
			end_y     <= cy_hi ? OUT_W'(OUT_MAX) : (cy_lo ? OUT_W'(OUT_MIN) : OUT_W'(sy));
			clipped   <= cx_hi || cx_lo || cy_hi || cy_lo;
		end
	end

endmodule

FILE: test/tb_laser_scan_endpoint_projection_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for laser_scan_endpoint_projection_top: scans, range windows and
// register settings driven through the stream and register ports, end points predicted by a
// CORDIC model in a scoreboard class. Depends on lsep_pkg, lsep_if and the block's RTL.
module tb_laser_scan_endpoint_projection_top;
	import lsep_pkg::*;

	localparam int     PIPE_LAT    = CORDIC_STAGES + 5;
	localparam int     HOLD_CYCLES = 200;
	localparam int     ANG_MAX     = 25736;
	localparam longint ANG_PI      = 64'sd52707179;
	localparam longint ANG_TWO_PI  = 64'sd105414357;
	localparam longint ANG_HALF_PI = 64'sd26353589;
	localparam longint RANGE_GAIN  = 64'sd39797;
	localparam longint COORD_MAX   = 64'sd8388607;
	localparam longint COORD_MIN   = -64'sd8388608;
	localparam longint ARCTAN_Q24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               clip;
	} endpoint_t;

	class endpoint_scoreboard;
		logic signed [15:0] start_ang, stop_ang, ang_step, heading, next_ang;
		logic [15:0]        min_mm, max_mm;
		logic signed [23:0] off_x, off_y;
		endpoint_t          due_points[$];
		int                 mismatches, samples, points, clipped_points, dropped;

		function new();
			start_ang = '0;
			stop_ang = '0;
			ang_step = '0;
			heading = '0;
			next_ang = '0;
			min_mm = '0;
			max_mm = 16'hFFFF;
			off_x = '0;
			off_y = '0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void write_reg(cfg_idx_t idx, logic [23:0] d);
			case (idx)
				REG_START_ANGLE: start_ang = d[15:0];
				REG_END_ANGLE:   stop_ang = d[15:0];
				REG_ANGLE_STEP:  ang_step = d[15:0];
				REG_MIN_RANGE:   min_mm = d[15:0];
				REG_MAX_RANGE:   max_mm = d[15:0];
				REG_HEADING:     heading = d[15:0];
				REG_OFFSET_X:    off_x = d;
				REG_OFFSET_Y:    off_y = d;
				default: ;
			endcase
		endfunction

		function longint saturate(longint v, inout bit clip);
			if (v > COORD_MAX) begin
				clip = 1'b1;
				return COORD_MAX;
			end
			if (v < COORD_MIN) begin
				clip = 1'b1;
				return COORD_MIN;
			end
			return v;
		endfunction

		// Predict the end point of one accepted sample and step the beam angle.
		function void note_sample(logic [15:0] r, logic fb);
			longint    beam, z, x, y, t, sum, lim;
			bit        neg, clip;
			int        i;
			endpoint_t e;
			samples++;
			beam = fb ? longint'(start_ang) : longint'(next_ang);
			if (r >= min_mm && r < max_mm) begin
				z = (beam + longint'(heading)) * 2048;
				if (z > ANG_PI) z -= ANG_TWO_PI;
				if (z > ANG_PI) z -= ANG_TWO_PI;
				if (z < -ANG_PI) z += ANG_TWO_PI;
				if (z < -ANG_PI) z += ANG_TWO_PI;
				neg = 1'b0;
				if (z > ANG_HALF_PI) begin
					z -= ANG_PI;
					neg = 1'b1;
				end else if (z < -ANG_HALF_PI) begin
					z += ANG_PI;
					neg = 1'b1;
				end
				x = longint'(r) * RANGE_GAIN;
				y = 0;
				for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
					if (z >= 0) begin
						t = x - (y >>> i);
						y = y + (x >>> i);
						z -= ARCTAN_Q24[i];
					end else begin
						t = x + (y >>> i);
						y = y - (x >>> i);
						z += ARCTAN_Q24[i];
					end
					x = t;
				end
				if (neg) begin
					x = -x;
					y = -y;
				end
				clip = 1'b0;
				x = saturate(((x + 32768) >>> 16) + longint'(off_x), clip);
				y = saturate(((y + 32768) >>> 16) + longint'(off_y), clip);
				e.x = x[23:0];
				e.y = y[23:0];
				e.clip = clip;
				due_points.insert(due_points.size(), e);
			end else begin
				dropped++;
			end
			sum = beam + longint'(ang_step);
			lim = longint'(stop_ang);
			if ((lim < 0 && sum <= lim) || (lim >= 0 && sum >= lim))
				next_ang = start_ang;
			else
				next_ang = sum[15:0];
		endfunction

		function void check_point(logic signed [23:0] gx, logic signed [23:0] gy, logic gc);
			endpoint_t e;
			points++;
			if (gc === 1'b1)
				clipped_points++;
			if (due_points.size() == 0) begin
				flag($sformatf("unexpected end point (%0d, %0d, clipped %0b)", gx, gy, gc));
				return;
			end
			e = due_points.pop_front();
			if (gx !== e.x || gy !== e.y || gc !== e.clip)
				flag($sformatf("end point %0d: expected (%0d, %0d, clipped %0b) got (%0d, %0d, clipped %0b)",
					points, e.x, e.y, e.clip, gx, gy, gc));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lsep_in_if  scan_if ();
	lsep_out_if point_if ();
	lsep_cfg_if cfg_if ();

	laser_scan_endpoint_projection_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_if),
		.point  (point_if),
		.cfg    (cfg_if)
	);

	endpoint_scoreboard sb;
	bit quiet;
	bit hold_req;
	int stall_pct;
	int gap_pct;
	int settings;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.write_reg(cfg_idx_t'(cfg_if.index), cfg_if.data);
			if (scan_if.valid && scan_if.ready)
				sb.note_sample(scan_if.range_mm, scan_if.first_beam);
			if (point_if.valid && point_if.ready)
				sb.check_point(point_if.end_x, point_if.end_y, point_if.clipped);
		end
	end

	initial begin : result_sink
		point_if.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				point_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				point_if.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				point_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb_laser_scan_endpoint_projection_top failed");
		$finish;
	end

	function automatic int rand_angle();
		return int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
	endfunction

	function automatic int edge_angle();
		return $urandom_range(0, 1) ? ANG_MAX : -ANG_MAX;
	endfunction

	function automatic int rand_offset();
		case ($urandom_range(0, 3))
			0: return int'($urandom);
			1: return 8388607 - int'($urandom_range(0, 70000));
			2: return -8388608 + int'($urandom_range(0, 70000));
			default: return int'($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	function automatic logic [15:0] pick_range();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'(sb.min_mm + $urandom_range(0, 2) - 1)
				: 16'(sb.max_mm + $urandom_range(0, 2) - 1);
			default: begin
				if (sb.min_mm < sb.max_mm)
					return 16'($urandom_range(sb.min_mm, sb.max_mm - 1));
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic send_sample(input logic [15:0] r, input logic fb);
		scan_if.valid <= 1'b1;
		scan_if.range_mm <= r;
		scan_if.first_beam <= fb;
		do @(posedge clk); while (!scan_if.ready);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input int v);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= 24'(v);
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic setup(input int a0, a1, a2, a3, a4, a5, a6, a7);
		write_cfg(REG_START_ANGLE, a0);
		write_cfg(REG_END_ANGLE, a1);
		write_cfg(REG_ANGLE_STEP, a2);
		write_cfg(REG_MIN_RANGE, a3);
		write_cfg(REG_MAX_RANGE, a4);
		write_cfg(REG_HEADING, a5);
		write_cfg(REG_OFFSET_X, a6);
		write_cfg(REG_OFFSET_Y, a7);
		cfg_if.valid <= 1'b0;
		settings++;
	endtask

	task automatic random_setup(input bit extreme);
		int lo, hi, step;
		if ($urandom_range(0, 4) == 0) begin
			lo = $urandom_range(0, 65535);
			hi = $urandom_range(0, 65535);
		end else begin
			lo = $urandom_range(0, 3000);
			hi = $urandom_range(40000, 65535);
		end
		if (extreme)
			step = edge_angle();
		else if ($urandom_range(0, 3) == 0)
			step = rand_angle();
		else
			step = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 4000));
		if (extreme)
			setup(edge_angle(), edge_angle(), step, lo, hi, edge_angle(), rand_offset(),
				rand_offset());
		else
			setup(rand_angle(), rand_angle(), step, lo, hi, rand_angle(), rand_offset(),
				rand_offset());
	endtask

	// Scans of random length opened by a first-beam flag, with stray flags mixed in.
	task automatic run_scans(input int count);
		int k, left;
		logic fb;
		left = 0;
		for (k = 0; k < count; k++) begin
			if (left == 0) begin
				left = $urandom_range(4, 48);
				fb = 1'b1;
			end else begin
				fb = ($urandom_range(0, 19) == 0);
			end
			left--;
			if (!quiet && $urandom_range(0, 99) < gap_pct) begin
				scan_if.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			send_sample(pick_range(), fb);
		end
	endtask

	// Wait until every end point is out, then let the pipeline empty.
	task automatic settle();
		scan_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_points.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin : stimulus
		int p;
		sb = new();
		arst_n = 1'b0;
		scan_if.valid = 1'b0;
		scan_if.range_mm = '0;
		scan_if.first_beam = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_START_ANGLE;
		cfg_if.data = '0;
		stall_pct = 10;
		gap_pct = 10;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: beam angle unflagged at first, top range excluded
		send_sample(16'd0, 1'b0);
		send_sample(16'd65535, 1'b0);
		send_sample(16'd65534, 1'b0);
		send_sample(16'd1, 1'b1);
		settle();

		// window edges, saturation on both coordinates
		setup(-ANG_MAX, ANG_MAX, 3217, 100, 60000, ANG_MAX, 8388607, -8388608);
		send_sample(16'd0, 1'b1);
		send_sample(16'd99, 1'b0);
		send_sample(16'd100, 1'b0);
		send_sample(16'd59999, 1'b0);
		send_sample(16'd60000, 1'b0);
		send_sample(16'd65535, 1'b0);
		send_sample(16'd30000, 1'b1);
		send_sample(16'd12345, 1'b0);
		settle();

		// empty window
		setup(0, 0, 0, 5000, 5000, 0, 0, 0);
		send_sample(16'd5000, 1'b1);
		send_sample(16'd4999, 1'b0);
		send_sample(16'd65535, 1'b0);
		settle();

		// negative end angle, largest negative step and heading
		setup(ANG_MAX, -ANG_MAX, -ANG_MAX, 0, 65535, -ANG_MAX, 0, 0);
		send_sample(16'd65534, 1'b1);
		send_sample(16'd1, 1'b0);
		send_sample(16'd40000, 1'b0);
		send_sample(16'd65535, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd20000, 1'b1);
		settle();

		for (p = 0; p < 7; p++) begin
			stall_pct = (p % 3 == 2) ? 0 : 10;
			gap_pct = (p % 3 == 2) ? 0 : 10;
			random_setup(p == 0 || p == 5);
			if (p == 3) begin
				hold_req = 1'b1;
				run_scans(60);
			end
			run_scans(90);
			settle();
		end

		quiet = 1'b1;
		random_setup(1'b0);
		run_scans(100);
		settle();

		$display("Covered %0d samples over %0d register settings: %0d end points checked",
			sb.samples, settings, sb.points);
		$display("(%0d clipped), %0d samples outside the range window.",
			sb.clipped_points, sb.dropped);
		if (sb.mismatches == 0 && sb.due_points.size() == 0)
			$display("tb_laser_scan_endpoint_projection_top passed");
		else
			$display("tb_laser_scan_endpoint_projection_top failed");
		$finish;
	end
endmodule
